// ===== design/msfs_pkg.sv =====
// ----------------------------------------------------------------------------
// msfs_pkg
// shared types and codes for the frame synchroniser controller and datapath
// ----------------------------------------------------------------------------
package msfs_pkg;

  // configuration register indexes
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENSOR_ENABLE = 2'd0,
    REG_STRICT_MASK   = 2'd1,
    REG_STRICT_GAP    = 2'd2,
    REG_LATEST_GAP    = 2'd3
  } msfs_reg_e;

  // fixed field widths
  localparam int IndexW  = 3;
  localparam int StampW  = 64;
  localparam int MaskW   = 8;
  localparam int GapW    = 32;
  localparam int OutHndW = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRUNE,
    ST_CHECK,
    ST_EMIT
  } msfs_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic prune_en;
    logic ptr_clr;
    logic ptr_inc;
    logic emit_load;
    logic clear_strict;
  } msfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic arr_strict;
    logic ptr_last;
    logic full;
    logic out_free;
    logic slot_en;
    logic emit_last;
  } msfs_sts_t;

endpackage

// ===== design/msfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// msfs_ctrl
// sequencer: accept, prune scan, completeness check, bundle emission
// ----------------------------------------------------------------------------
module msfs_ctrl import msfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  msfs_sts_t sts_i,
  output msfs_cmd_t cmd_o
);

  msfs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.arr_strict) begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = ST_PRUNE;
        end
      end
      ST_PRUNE: begin
        cmd_o.prune_en = 1'b1;
        if (sts_i.ptr_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d       = ST_CHECK;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      ST_CHECK: begin
        state_d = sts_i.full ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!sts_i.slot_en) begin
          // disabled slot, step over it
          if (sts_i.ptr_last) begin
            cmd_o.clear_strict = 1'b1;
            state_d            = ST_IDLE;
          end else begin
            cmd_o.ptr_inc = 1'b1;
          end
        end else if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear_strict = 1'b1;
            state_d            = ST_IDLE;
          end else begin
            cmd_o.ptr_inc = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/msfs_dp.sv =====
// ----------------------------------------------------------------------------
// msfs_dp
// slot store, config registers, gap comparator and output register
// ----------------------------------------------------------------------------
module msfs_dp import msfs_pkg::*; #(
  parameter int NUM_SENSORS = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_wdata_i,
  input  logic [IndexW-1:0]      in_index_i,
  input  logic [HANDLE_BITS-1:0] in_handle_i,
  input  logic [StampW-1:0]      in_stamp_i,
  input  msfs_cmd_t              cmd_i,
  output msfs_sts_t              sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [IndexW-1:0]      out_index_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic [StampW-1:0]      out_stamp_o,
  output logic                   out_last_o
);

  // slots above the width of the masks can never be enabled
  localparam int Slots = (NUM_SENSORS < MaskW) ? NUM_SENSORS : MaskW;
  localparam int PtrW  = (Slots > 1) ? $clog2(Slots) : 1;

  // config registers
  logic [MaskW-1:0] enable_q, strict_q;
  logic [GapW-1:0]  strict_gap_q, latest_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= '0;
      strict_q     <= '0;
      strict_gap_q <= '0;
      latest_gap_q <= '0;
    end else if (cfg_we_i) begin
      unique case (msfs_reg_e'(cfg_idx_i))
        REG_SENSOR_ENABLE: enable_q     <= cfg_wdata_i[MaskW-1:0];
        REG_STRICT_MASK:   strict_q     <= cfg_wdata_i[MaskW-1:0];
        REG_STRICT_GAP:    strict_gap_q <= cfg_wdata_i[GapW-1:0];
        REG_LATEST_GAP:    latest_gap_q <= cfg_wdata_i[GapW-1:0];
        default: ;
      endcase
    end
  end

  logic [Slots-1:0] en_v, strict_v;
  assign en_v     = enable_q[Slots-1:0];
  assign strict_v = strict_q[Slots-1:0];

  // arrival decode
  logic            in_hit;
  logic [PtrW-1:0] in_slot;
  assign in_hit  = ({{(32-IndexW){1'b0}}, in_index_i} < 32'(Slots));
  assign in_slot = PtrW'(in_index_i);

  // slot store
  logic [Slots-1:0]       valid_q, valid_d;
  logic [HANDLE_BITS-1:0] handle_q [Slots];
  logic [StampW-1:0]      stamp_q  [Slots];
  logic [StampW-1:0]      arr_stamp_q;
  logic [PtrW-1:0]        ptr_q;
  logic                   store;

  assign store = cmd_i.accept && in_hit && en_v[in_slot];

  always_ff @(posedge clk_i) begin
    if (store) begin
      handle_q[in_slot] <= in_handle_i;
      stamp_q[in_slot]  <= in_stamp_i;
      arr_stamp_q       <= in_stamp_i;
    end
  end

  // gap of the scanned slot against the arrival
  logic [StampW:0]   diff_ab;
  logic [StampW-1:0] gap;
  logic [GapW-1:0]   lim;
  logic              over;

  always_comb begin
    diff_ab = {1'b0, arr_stamp_q} - {1'b0, stamp_q[ptr_q]};
    gap     = diff_ab[StampW] ? (stamp_q[ptr_q] - arr_stamp_q) : diff_ab[StampW-1:0];
    lim     = strict_v[ptr_q] ? strict_gap_q : latest_gap_q;
    over    = (|gap[StampW-1:GapW]) || (gap[GapW-1:0] > lim);
  end

  always_comb begin
    valid_d = valid_q;
    if (store) begin
      valid_d[in_slot] = 1'b1;
    end
    if (cmd_i.prune_en && en_v[ptr_q] && valid_q[ptr_q] && over) begin
      valid_d[ptr_q] = 1'b0;
    end
    if (cmd_i.clear_strict) begin
      valid_d = valid_d & ~(en_v & strict_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + PtrW'(1);
      end
    end
  end

  // any enabled slot above the pointer
  logic more;
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < Slots; j++) begin
      if ((PtrW'(j) > ptr_q) && en_v[j]) begin
        more = 1'b1;
      end
    end
  end

  // output register
  logic                   out_valid_q;
  logic [IndexW-1:0]      out_index_q;
  logic [HANDLE_BITS-1:0] out_handle_q;
  logic [StampW-1:0]      out_stamp_q;
  logic                   out_last_q;
  logic [HANDLE_BITS-1:0] handle_trim;

  // bundle handles keep only their low sixteen bits
  always_comb begin
    for (int b = 0; b < HANDLE_BITS; b++) begin
      handle_trim[b] = handle_q[ptr_q][b] & (b < OutHndW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_index_q  <= IndexW'(ptr_q);
      out_handle_q <= handle_trim;
      out_stamp_q  <= stamp_q[ptr_q];
      out_last_q   <= !more;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign out_handle_o = out_handle_q;
  assign out_stamp_o  = out_stamp_q;
  assign out_last_o   = out_last_q;

  // status
  assign sts_o.arr_strict = in_hit && en_v[in_slot] && strict_v[in_slot];
  assign sts_o.ptr_last   = (ptr_q == PtrW'(Slots - 1));
  assign sts_o.full       = &(valid_q | ~en_v);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.slot_en    = en_v[ptr_q];
  assign sts_o.emit_last  = !more;

endmodule

// ===== design/multi_sensor_frame_synchronizer.sv =====
// ----------------------------------------------------------------------------
// multi_sensor_frame_synchronizer
// bundles frames from several sensors whose timestamps agree within limits
// ----------------------------------------------------------------------------
// ignored, disabled or latest-group arrival is accepted in idle and stays there
// strict arrival: accept, prune scan over S = min(NUM_SENSORS, 8) slots, check;
//   if every enabled slot is valid, emission runs up to the last enabled one, stalling on the output
// first bundle entry is loaded after the check and any disabled slots below it;
//   a bundling arrival holds the input until its emission is done
// reset: controller, config registers, slot valid bits and output valid clear;
//   slot contents are left as they are and stay hidden until rewritten
module multi_sensor_frame_synchronizer import msfs_pkg::*; #(
  parameter int NUM_SENSORS = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // frame arrivals
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sensor_index, frame_handle, stamp_us (lowest bit up), zero padded
  input  logic [((IndexW + HANDLE_BITS + StampW + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // bundle entries
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // slot_index, bundle_handle, bundle_stamp (lowest bit up), zero padded
  output logic [((IndexW + HANDLE_BITS + StampW + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // marks the final entry of a bundle
  output logic                m_axis_tlast
);

  localparam int PayW  = IndexW + HANDLE_BITS + StampW;
  localparam int DataW = ((PayW + 7) / 8) * 8;

  msfs_cmd_t cmd;
  msfs_sts_t sts;

  logic [IndexW-1:0]      out_index;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [StampW-1:0]      out_stamp;

  // sequencer: owns the input handshake and drives the datapath commands
  msfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot store, gap compare and output register
  msfs_dp #(
    .NUM_SENSORS (NUM_SENSORS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_index_i   (s_axis_tdata[IndexW-1:0]),
    .in_handle_i  (s_axis_tdata[IndexW +: HANDLE_BITS]),
    .in_stamp_i   (s_axis_tdata[IndexW + HANDLE_BITS +: StampW]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_index_o  (out_index),
    .out_handle_o (out_handle),
    .out_stamp_o  (out_stamp),
    .out_last_o   (m_axis_tlast)
  );

  // pack result fields, zero filled up to the byte boundary
  assign m_axis_tdata = DataW'({out_stamp, out_handle, out_index});

endmodule
